### sv/nnsag_pkg.sv
// nnsag_pkg: shared types, constants and the size clamp of the rescale address generator.
// No dependencies; every other file in this folder refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package nnsag_pkg;

  localparam int DIM_W       = 11;          // width of every size and walk counter
  localparam int ADDR_W      = 20;          // width of linear pixel addresses
  localparam int PROD_W      = 2 * DIM_W;   // rows-per-step times source width
  localparam int CFG_IDX_W   = 3;
  localparam int MAXD_W      = 13;          // holds the largest allowed MAX_DIM
  localparam int MAX_DIM_DEF = 1024;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_H,
    S_DIV_V,
    S_MUL,
    S_STEP
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_TGT_W = 3'd2,
    REG_TGT_H = 3'd3
  } cfg_reg_t;

  // Clamped sizes the walker needs on every pixel.
  typedef struct packed {
    dim_t src_w;
    dim_t tgt_w;
    dim_t tgt_h;
  } dims_t;

  // Sequencer commands to the walker.
  typedef struct packed {
    logic load_h;
    logic load_v;
    logic frame_start;
    logic mul;
    logic step;
  } ctl_t;

  typedef struct packed {
    addr_t source_address;
    addr_t target_address;
    logic  row_repeat;
    logic  last_in_row;
    logic  last_in_frame;
  } result_t;

  // Zero reads as one, anything above the limit reads as the limit.
  function automatic dim_t clamp_dim(input dim_t v, input logic [MAXD_W-1:0] max_dim);
    logic [MAXD_W-1:0] v_ext;
    v_ext = MAXD_W'(v);
    if (v == '0) return DIM_W'(1);
    if (v_ext > max_dim) return max_dim[DIM_W-1:0];
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/nnsag_div.sv
// nnsag_div: shared restoring divider, one quotient bit per cycle.
// Depends on nnsag_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire nnsag_pkg::dim_t dividend,
  input  wire nnsag_pkg::dim_t divisor,
  output logic                 done,
  output nnsag_pkg::dim_t      quotient,
  output nnsag_pkg::dim_t      remainder
);

  localparam int W     = nnsag_pkg::DIM_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  nnsag_pkg::dim_t  quo_r;
  nnsag_pkg::dim_t  rem_r;
  nnsag_pkg::dim_t  dvs_r;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       fits;

  assign shifted = {rem_r, quo_r[W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[W-2:0], fits};
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### sv/nnsag_walk.sv
// nnsag_walk: Bresenham walk state (row base, column offset, error terms, counters).
// Depends on nnsag_pkg; commanded by the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_walk (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nnsag_pkg::ctl_t    ctl,
  input  wire nnsag_pkg::dims_t   dims,
  input  wire nnsag_pkg::dim_t    quotient,
  input  wire nnsag_pkg::dim_t    remainder,
  output nnsag_pkg::result_t      res,
  output logic                    frame_active
);

  localparam int DW = nnsag_pkg::DIM_W;
  localparam int AW = nnsag_pkg::ADDR_W;

  nnsag_pkg::addr_t            row_base_r;
  nnsag_pkg::dim_t             col_off_r;
  nnsag_pkg::dim_t             herr_r;
  nnsag_pkg::dim_t             verr_r;
  nnsag_pkg::dim_t             tcol_r;
  nnsag_pkg::dim_t             trow_r;
  nnsag_pkg::addr_t            tlin_r;
  logic                        rep_r;
  nnsag_pkg::dim_t             hstep_r;
  nnsag_pkg::dim_t             hrem_r;
  nnsag_pkg::dim_t             vstep_r;
  nnsag_pkg::dim_t             vrem_r;
  nnsag_pkg::addr_t            prod_r;
  logic                        frame_active_r;

  logic             end_row;
  logic             end_frame;
  nnsag_pkg::dim_t  vsum;
  logic             vcarry;
  nnsag_pkg::dim_t  verr_nxt;
  nnsag_pkg::addr_t row_base_nxt;
  nnsag_pkg::dim_t  hsum;
  logic             hcarry;
  nnsag_pkg::dim_t  herr_nxt;
  nnsag_pkg::dim_t  col_off_nxt;

  always_comb begin
    end_row   = tcol_r >= (dims.tgt_w - DW'(1));
    end_frame = end_row && (trow_r >= (dims.tgt_h - DW'(1)));

    vsum         = verr_r + vrem_r;
    vcarry       = vsum >= dims.tgt_h;
    verr_nxt     = vcarry ? (vsum - dims.tgt_h) : vsum;
    row_base_nxt = row_base_r + prod_r + (vcarry ? AW'(dims.src_w) : '0);

    hsum        = herr_r + hrem_r;
    hcarry      = hsum >= dims.tgt_w;
    herr_nxt    = hcarry ? (hsum - dims.tgt_w) : hsum;
    col_off_nxt = col_off_r + hstep_r + DW'(hcarry);

    res.source_address = row_base_r + AW'(col_off_r);
    res.target_address = tlin_r;
    res.row_repeat     = rep_r;
    res.last_in_row    = end_row;
    res.last_in_frame  = end_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
    end else if (ctl.frame_start) begin
      frame_active_r <= 1'b1;
    end else if (ctl.step && end_frame) begin
      frame_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_h) begin
      hstep_r <= quotient;
      hrem_r  <= remainder;
    end
    if (ctl.load_v) begin
      vstep_r <= quotient;
      vrem_r  <= remainder;
    end
    if (ctl.mul) begin
      prod_r <= AW'(nnsag_pkg::PROD_W'(vstep_r) * nnsag_pkg::PROD_W'(dims.src_w));
    end
    if (ctl.frame_start) begin
      row_base_r <= '0;
      col_off_r  <= '0;
      herr_r     <= '0;
      verr_r     <= '0;
      tcol_r     <= '0;
      trow_r     <= '0;
      tlin_r     <= '0;
      rep_r      <= 1'b0;
    end else if (ctl.step) begin
      tlin_r <= tlin_r + AW'(1);
      if (end_frame) begin
        // frame closes; the next item starts a fresh one
      end else if (end_row) begin
        verr_r     <= verr_nxt;
        rep_r      <= (row_base_nxt == row_base_r);
        row_base_r <= row_base_nxt;
        col_off_r  <= '0;
        herr_r     <= '0;
        tcol_r     <= '0;
        trow_r     <= trow_r + DW'(1);
      end else begin
        herr_r    <= herr_nxt;
        col_off_r <= col_off_nxt;
        tcol_r    <= tcol_r + DW'(1);
      end
    end
  end

  assign frame_active = frame_active_r;

endmodule

`default_nettype wire

### sv/nearest_neighbor_scale_address_gen.sv
// nearest_neighbor_scale_address_gen: top level, size registers, sequencer, result register.
// Depends on nnsag_pkg, nnsag_div and nnsag_walk.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in_     | input     | in_valid / in_ready   | in_restart
//   out_    | output    | out_valid / out_ready | out_source_address, out_target_address,
//           |           |                       | out_row_repeat, out_last_in_row,
//           |           |                       | out_last_in_frame
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A pixel transaction inside a frame runs from accept through the row-step multiply and the
// walk update to the next accept; the result is loaded into the output register at the
// update edge. The first pixel of a frame (restart, after the last pixel, or after reset)
// adds two passes through the shared bit-serial divider before the multiply.
// Reset (synchronous, rst_n low) loads the default sizes and marks no frame open.
// A result not taken holds the sequencer in its update state; input is taken only when idle.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_scale_address_gen #(
  parameter int MAX_DIM = nnsag_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_restart,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [nnsag_pkg::ADDR_W-1:0]           out_source_address,
  output logic [nnsag_pkg::ADDR_W-1:0]           out_target_address,
  output logic                                   out_row_repeat,
  output logic                                   out_last_in_row,
  output logic                                   out_last_in_frame,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nnsag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nnsag_pkg::DIM_W-1:0]       cfg_data
);

  localparam logic [nnsag_pkg::MAXD_W-1:0] MAX_DIM_V = nnsag_pkg::MAXD_W'(MAX_DIM);

  // Size registers, raw as written.
  nnsag_pkg::dim_t src_w_r, src_h_r, tgt_w_r, tgt_h_r;

  nnsag_pkg::dims_t    dims;
  nnsag_pkg::dim_t     src_h_dim;
  nnsag_pkg::state_t   state_r, state_nxt;
  nnsag_pkg::ctl_t     ctl;
  nnsag_pkg::result_t  walk_res;
  nnsag_pkg::result_t  res_r;
  logic                out_valid_r;
  logic                load_out;
  logic                frame_active;
  logic                div_start;
  logic                div_done;
  nnsag_pkg::dim_t     div_dividend, div_divisor;
  nnsag_pkg::dim_t     div_quo, div_rem;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnsag_pkg::DIM_W'(320);
      src_h_r <= nnsag_pkg::DIM_W'(240);
      tgt_w_r <= nnsag_pkg::DIM_W'(160);
      tgt_h_r <= nnsag_pkg::DIM_W'(120);
    end else if (cfg_valid) begin
      case (cfg_index)
        nnsag_pkg::REG_SRC_W: src_w_r <= cfg_data;
        nnsag_pkg::REG_SRC_H: src_h_r <= cfg_data;
        nnsag_pkg::REG_TGT_W: tgt_w_r <= cfg_data;
        nnsag_pkg::REG_TGT_H: tgt_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.src_w = nnsag_pkg::clamp_dim(src_w_r, MAX_DIM_V);
    dims.tgt_w = nnsag_pkg::clamp_dim(tgt_w_r, MAX_DIM_V);
    dims.tgt_h = nnsag_pkg::clamp_dim(tgt_h_r, MAX_DIM_V);
    src_h_dim  = nnsag_pkg::clamp_dim(src_h_r, MAX_DIM_V);
  end

  // Divider operands: widths on the start from idle, heights on the second pass.
  assign div_dividend = (state_r == nnsag_pkg::S_IDLE) ? dims.src_w : src_h_dim;
  assign div_divisor  = (state_r == nnsag_pkg::S_IDLE) ? dims.tgt_w : dims.tgt_h;

  nnsag_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  nnsag_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .dims         (dims),
    .quotient     (div_quo),
    .remainder    (div_rem),
    .res          (walk_res),
    .frame_active (frame_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnsag_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: optional frame setup (two divisions), then multiply, then walk update.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    in_ready  = (state_r == nnsag_pkg::S_IDLE);
    case (state_r)
      nnsag_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_restart || !frame_active) begin
            div_start = 1'b1;
            state_nxt = nnsag_pkg::S_DIV_H;
          end else begin
            state_nxt = nnsag_pkg::S_MUL;
          end
        end
      end
      nnsag_pkg::S_DIV_H: begin
        if (div_done) begin
          ctl.load_h = 1'b1;
          div_start  = 1'b1;
          state_nxt  = nnsag_pkg::S_DIV_V;
        end
      end
      nnsag_pkg::S_DIV_V: begin
        if (div_done) begin
          ctl.load_v      = 1'b1;
          ctl.frame_start = 1'b1;
          state_nxt       = nnsag_pkg::S_MUL;
        end
      end
      nnsag_pkg::S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = nnsag_pkg::S_STEP;
      end
      nnsag_pkg::S_STEP: begin
        // hold here until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          ctl.step  = 1'b1;
          load_out  = 1'b1;
          state_nxt = nnsag_pkg::S_IDLE;
        end
      end
      default: state_nxt = nnsag_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r <= walk_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_source_address = res_r.source_address;
  assign out_target_address = res_r.target_address;
  assign out_row_repeat     = res_r.row_repeat;
  assign out_last_in_row    = res_r.last_in_row;
  assign out_last_in_frame  = res_r.last_in_frame;

endmodule

`default_nettype wire

### sv/nnsag_checker.sv
// nnsag_checker: port-level assertions for the rescale address generator, and its bind.
// Depends on nnsag_pkg and on the top level nearest_neighbor_scale_address_gen.
`timescale 1ns / 1ps
`default_nettype none

module nnsag_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [nnsag_pkg::ADDR_W-1:0] out_source_address,
  input wire logic [nnsag_pkg::ADDR_W-1:0] out_target_address,
  input wire logic                         out_last_in_row,
  input wire logic                         out_last_in_frame
);

  // One transaction at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again on the cycle after an accept");

  // End of frame is always also end of row.
  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_frame |-> out_last_in_row)
    else $error("last_in_frame without last_in_row");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_address)
      && $stable(out_target_address))
    else $error("stalled result changed or dropped");

  // Nothing to show after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nearest_neighbor_scale_address_gen nnsag_checker u_nnsag_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_source_address (out_source_address),
  .out_target_address (out_target_address),
  .out_last_in_row    (out_last_in_row),
  .out_last_in_frame  (out_last_in_frame)
);

`default_nettype wire
